### hdl/object_record_loader_parser_macros.svh
// Assertion helpers for the object record loader parser.
`ifndef OBJECT_RECORD_LOADER_PARSER_MACROS_SVH
`define OBJECT_RECORD_LOADER_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ORLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ORLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/orlp_pkg.sv
package orlp_pkg;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_CD_ADDR  = 4'd1,
    PH_CD_LEN   = 4'd2,
    PH_CD_DATA  = 4'd3,
    PH_SYM_ADDR = 4'd4,
    PH_SYM_LEN  = 4'd5,
    PH_SKIP     = 4'd6,
    PH_FN_LEN   = 4'd7,
    PH_LINE     = 4'd8
  } phase_t;

  localparam logic [15:0] HDR_CODE = 16'hCADE;
  localparam logic [15:0] HDR_DATA = 16'hDADA;
  localparam logic [15:0] HDR_SYM  = 16'hC3B7;
  localparam logic [15:0] HDR_FILE = 16'hF17E;
  localparam logic [15:0] HDR_LINE = 16'h715E;

  localparam logic EV_STORE = 1'b0;
  localparam logic EV_ERROR = 1'b1;

  // Line-number records carry this many words after the header, minus one.
  localparam logic [1:0] LINE_LAST_FIELD = 2'd2;

  localparam int unsigned OUT_DATA_W = 32;
  localparam int unsigned OUT_USER_W = 2;

  typedef struct packed {
    logic [OUT_USER_W-1:0] user;
    logic [OUT_DATA_W-1:0] data;
  } out_item_t;

endpackage

### hdl/object_record_loader_parser.sv
// A result is registered into the output stage when the byte that completes it is accepted.
// Throughput: one byte per cycle while in_tready is high; the parser state updates at the accept edge.
// A two-entry output stage (register plus skid) keeps in_tready high while one
// result waits; in_tready drops only while both entries are full.
// Reset (rst_n low, synchronous): parser back to header state, output stage empty.
module object_record_loader_parser (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] data_byte
  input  logic                              in_tlast,   // last_of_file
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [orlp_pkg::OUT_DATA_W-1:0]   out_tdata,  // [15:0] address, [31:16] word
  output logic [orlp_pkg::OUT_USER_W-1:0]   out_tuser   // [0] event_res, [1] is_code
);
  import orlp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        have_high_r, have_high_nxt;
  logic [7:0]  high_byte_r, high_byte_nxt;
  logic        rec_code_r, rec_code_nxt;
  logic [15:0] load_addr_r, load_addr_nxt;
  logic [15:0] remaining_r, remaining_nxt;
  logic [1:0]  field_cnt_r, field_cnt_nxt;

  logic        in_accept;
  logic [15:0] word_w;
  logic [15:0] rem_dec;
  logic        res_valid;
  out_item_t   res_item;

  out_item_t   out_item_r, out_item_nxt;
  out_item_t   skid_item_r, skid_item_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic        out_take;

  assign in_tready = !skid_valid_r;
  assign in_accept = in_tvalid && in_tready;
  assign word_w    = {high_byte_r, in_tdata};
  assign rem_dec   = remaining_r - 16'd1;

  always_comb begin
    phase_nxt     = phase_r;
    have_high_nxt = have_high_r;
    high_byte_nxt = high_byte_r;
    rec_code_nxt  = rec_code_r;
    load_addr_nxt = load_addr_r;
    remaining_nxt = remaining_r;
    field_cnt_nxt = field_cnt_r;
    res_valid     = 1'b0;
    res_item      = '0;

    if (in_accept) begin
      if (phase_r == PH_SKIP) begin
        // skipped bytes bypass word pairing
        remaining_nxt = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_nxt = PH_HEADER;
        end
      end else if (!have_high_r) begin
        high_byte_nxt = in_tdata;
        have_high_nxt = 1'b1;
      end else begin
        have_high_nxt = 1'b0;
        case (phase_r)
          PH_CD_ADDR: begin
            load_addr_nxt = word_w;
            phase_nxt     = PH_CD_LEN;
          end
          PH_CD_LEN: begin
            remaining_nxt = word_w;
            phase_nxt     = (word_w == 16'd0) ? PH_HEADER : PH_CD_DATA;
          end
          PH_CD_DATA: begin
            res_valid     = 1'b1;
            res_item.user = {rec_code_r, EV_STORE};
            res_item.data = {word_w, load_addr_r};
            load_addr_nxt = load_addr_r + 16'd1;
            remaining_nxt = rem_dec;
            if (rem_dec == 16'd0) begin
              phase_nxt = PH_HEADER;
            end
          end
          PH_SYM_ADDR: begin
            phase_nxt = PH_SYM_LEN;
          end
          PH_SYM_LEN, PH_FN_LEN: begin
            remaining_nxt = word_w;
            phase_nxt     = (word_w == 16'd0) ? PH_HEADER : PH_SKIP;
          end
          PH_LINE: begin
            if (field_cnt_r >= LINE_LAST_FIELD) begin
              field_cnt_nxt = 2'd0;
              phase_nxt     = PH_HEADER;
            end else begin
              field_cnt_nxt = field_cnt_r + 2'd1;
            end
          end
          default: begin
            // header decode; unused phase codes land here as well
            case (word_w)
              HDR_CODE, HDR_DATA: begin
                rec_code_nxt = (word_w == HDR_CODE);
                phase_nxt    = PH_CD_ADDR;
              end
              HDR_SYM: begin
                phase_nxt = PH_SYM_ADDR;
              end
              HDR_FILE: begin
                phase_nxt = PH_FN_LEN;
              end
              HDR_LINE: begin
                field_cnt_nxt = 2'd0;
                phase_nxt     = PH_LINE;
              end
              default: begin
                phase_nxt     = PH_HEADER;
                res_valid     = 1'b1;
                res_item.user = {1'b0, EV_ERROR};
                res_item.data = {word_w, 16'd0};
              end
            endcase
          end
        endcase
      end

      // end of file: drop any partial word or record
      if (in_tlast) begin
        phase_nxt     = PH_HEADER;
        have_high_nxt = 1'b0;
        remaining_nxt = 16'd0;
        field_cnt_nxt = 2'd0;
      end
    end
  end

  // Output register with one skid entry behind it.
  assign out_take = out_valid_r && out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_item_nxt   = out_item_r;
    skid_valid_nxt = skid_valid_r;
    skid_item_nxt  = skid_item_r;
    if (res_valid) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = res_item;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_item_nxt  = res_item;
      end
    end else if (out_take) begin
      if (skid_valid_r) begin
        out_item_nxt   = skid_item_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      have_high_r  <= 1'b0;
      high_byte_r  <= 8'd0;
      rec_code_r   <= 1'b0;
      load_addr_r  <= 16'd0;
      remaining_r  <= 16'd0;
      field_cnt_r  <= 2'd0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      have_high_r  <= have_high_nxt;
      high_byte_r  <= high_byte_nxt;
      rec_code_r   <= rec_code_nxt;
      load_addr_r  <= load_addr_nxt;
      remaining_r  <= remaining_nxt;
      field_cnt_r  <= field_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    skid_item_r <= skid_item_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_item_r.data;
  assign out_tuser  = out_item_r.user;

`include "object_record_loader_parser_macros.svh"

  `ORLP_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid entry full while output empty")
  `ORLP_ASSERT_NOW(a_skip_nonzero, phase_r == PH_SKIP, remaining_r != 16'd0, "skip phase with zero count")
  `ORLP_ASSERT_NOW(a_line_count, phase_r == PH_LINE, field_cnt_r <= LINE_LAST_FIELD, "line field count overflow")
  `ORLP_ASSERT_NEXT(a_eof_header, in_accept && in_tlast, phase_r == PH_HEADER && !have_high_r, "end of file did not return to header")

endmodule

### tb/sv/tb_object_record_loader_parser.sv
`timescale 1ns / 100ps

module tb_object_record_loader_parser;
  import orlp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_BYTES  = 230;

  typedef struct {
    logic        ev;
    logic [15:0] addr;
    logic [15:0] word;
    logic        code;
  } mem_event_t;

  typedef struct {
    logic [7:0] data_byte;
    logic       last;
  } stream_byte_t;

  class loader_scoreboard;
    phase_t      ph;
    logic        have_hi;
    logic [7:0]  hi;
    logic        rec_code;
    logic [15:0] load_addr;
    logic [15:0] remaining;
    logic [1:0]  line_field;
    mem_event_t  pending_events[$];
    int          error_count;

    function new();
      ph          = PH_HEADER;
      have_hi     = 1'b0;
      hi          = 8'd0;
      rec_code    = 1'b0;
      load_addr   = 16'd0;
      remaining   = 16'd0;
      line_field  = 2'd0;
      error_count = 0;
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
    endtask

    function void push_event(logic ev, logic [15:0] addr, logic [15:0] word, logic code);
      mem_event_t e;
      e.ev   = ev;
      e.addr = addr;
      e.word = word;
      e.code = code;
      pending_events.push_back(e);
    endfunction

    function void take_word(logic [15:0] w);
      case (ph)
        PH_CD_ADDR: begin
          load_addr = w;
          ph = PH_CD_LEN;
        end
        PH_CD_LEN: begin
          remaining = w;
          if (w == 16'd0) ph = PH_HEADER;
          else ph = PH_CD_DATA;
        end
        PH_CD_DATA: begin
          push_event(EV_STORE, load_addr, w, rec_code);
          load_addr = load_addr + 16'd1;
          remaining = remaining - 16'd1;
          if (remaining == 16'd0) ph = PH_HEADER;
        end
        PH_SYM_ADDR: ph = PH_SYM_LEN;
        PH_SYM_LEN, PH_FN_LEN: begin
          remaining = w;
          if (w == 16'd0) ph = PH_HEADER;
          else ph = PH_SKIP;
        end
        PH_LINE: begin
          if (line_field >= LINE_LAST_FIELD) begin
            line_field = 2'd0;
            ph = PH_HEADER;
          end else begin
            line_field = line_field + 2'd1;
          end
        end
        default: begin
          // decode the word as a record header
          case (w)
            HDR_CODE, HDR_DATA: begin
              rec_code = (w == HDR_CODE);
              ph = PH_CD_ADDR;
            end
            HDR_SYM: ph = PH_SYM_ADDR;
            HDR_FILE: ph = PH_FN_LEN;
            HDR_LINE: begin
              line_field = 2'd0;
              ph = PH_LINE;
            end
            default: begin
              ph = PH_HEADER;
              push_event(EV_ERROR, 16'd0, w, 1'b0);
            end
          endcase
        end
      endcase
    endfunction

    function void note_input(logic [7:0] b, logic last);
      // skipped bytes bypass word pairing
      if (ph == PH_SKIP) begin
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) ph = PH_HEADER;
      end else if (!have_hi) begin
        hi = b;
        have_hi = 1'b1;
      end else begin
        have_hi = 1'b0;
        take_word({hi, b});
      end
      if (last) begin
        ph         = PH_HEADER;
        have_hi    = 1'b0;
        remaining  = 16'd0;
        line_field = 2'd0;
      end
    endfunction

    task check_result(logic [31:0] tdata, logic [1:0] tuser);
      mem_event_t e;
      if (pending_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result data=%h user=%b", tdata, tuser));
        return;
      end
      e = pending_events.pop_front();
      if (tuser[0] !== e.ev)
        report_mismatch($sformatf("event_res %b, want %b", tuser[0], e.ev));
      if (tdata[15:0] !== e.addr)
        report_mismatch($sformatf("address %h, want %h", tdata[15:0], e.addr));
      if (tdata[31:16] !== e.word)
        report_mismatch($sformatf("word %h, want %h", tdata[31:16], e.word));
      if (tuser[1] !== e.code)
        report_mismatch($sformatf("is_code %b, want %b", tuser[1], e.code));
    endtask
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'd0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  loader_scoreboard scoreboard;
  stream_byte_t     byte_stream[$];
  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct     = 0;
  int unsigned      hold_request  = 0;
  int unsigned      hold_left     = 0;
  int unsigned      cycle_count   = 0;

  object_record_loader_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_object_record_loader_parser: errors");
      $finish;
    end
  end

  // result side: check accepted items, stall at random or for a requested stretch
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      scoreboard.check_result(out_tdata, out_tuser);
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic void put_byte(logic [7:0] b, logic last = 1'b0);
    stream_byte_t item;
    item.data_byte = b;
    item.last = last;
    byte_stream.push_back(item);
  endfunction

  function automatic void put_word(logic [15:0] w);
    put_byte(w[15:8]);
    put_byte(w[7:0]);
  endfunction

  function automatic void put_load_record(int unsigned count);
    logic [15:0] base;
    if ($urandom_range(4) == 0) base = 16'($urandom_range(16'hFFFF - 8, 16'hFFFF));
    else base = 16'($urandom);
    put_word(($urandom_range(1) == 1) ? HDR_CODE : HDR_DATA);
    put_word(base);
    put_word(16'(count));
    repeat (count) put_word(16'($urandom));
  endfunction

  function automatic void put_random_record();
    int unsigned kind  = $urandom_range(99);
    int unsigned count = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 6);
    int unsigned first = byte_stream.size();
    int unsigned cut;
    if (kind < 45) begin
      put_load_record(count);
    end else if (kind < 57) begin
      put_word(HDR_SYM);
      put_word(16'($urandom));
      put_word(16'(count));
      repeat (count) put_byte(8'($urandom));
    end else if (kind < 69) begin
      put_word(HDR_FILE);
      put_word(16'(count));
      repeat (count) put_byte(8'($urandom));
    end else if (kind < 81) begin
      put_word(HDR_LINE);
      repeat (3) put_word(16'($urandom));
    end else if (kind < 91) begin
      // noise: whole words stay aligned, an odd tail ends the file to realign
      repeat ($urandom_range(1, 6)) put_byte(8'($urandom));
      if ((byte_stream.size() - first) % 2 == 1)
        byte_stream[byte_stream.size() - 1].last = 1'b1;
    end else begin
      // truncate a load record and end the file inside it
      put_load_record(count);
      cut = $urandom_range(1, byte_stream.size() - first - 1);
      repeat (cut) void'(byte_stream.pop_back());
      byte_stream[byte_stream.size() - 1].last = 1'b1;
    end
    if ($urandom_range(9) == 0)
      byte_stream[byte_stream.size() - 1].last = 1'b1;
  endfunction

  task automatic send_byte(stream_byte_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata <= 8'($urandom);
      in_tlast <= 1'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= item.data_byte;
    in_tlast <= item.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scoreboard.note_input(item.data_byte, item.last);
  endtask

  task automatic send_stream();
    while (byte_stream.size() != 0) send_byte(byte_stream.pop_front());
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (scoreboard.pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    scoreboard = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // code record wrapping past the top address, ended by a lone high byte
    put_word(HDR_CODE);
    put_word(16'hFFFF);
    put_word(16'h0003);
    put_word(16'h0000);
    put_word(16'hFFFF);
    put_byte(8'hFF, 1'b1);
    put_word(HDR_FILE);
    put_word(16'h0000);
    put_word(HDR_SYM);
    put_word(16'h8001);
    put_word(16'h0001);
    put_byte(8'h5A);
    put_word(HDR_LINE);
    put_word(16'h00FF);
    put_word(16'hFF00);
    put_word(16'h7E81);
    put_word(16'h0180);
    send_stream();
    wait_drained();

    for (int ph_idx = 0; ph_idx < 4; ph_idx++) begin
      case (ph_idx)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          // hold the result side while a long data record streams in
          hold_request = 60;
          put_word(HDR_DATA);
          put_word(16'h1000);
          put_word(16'd20);
          repeat (20) put_word(16'($urandom));
        end
        1: begin
          send_idle_pct = 50;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 50;
        end
        default: begin
          send_idle_pct = 30;
          stall_pct = 30;
        end
      endcase
      while (byte_stream.size() < PHASE_BYTES) put_random_record();
      send_stream();
      wait_drained();
    end

    if (scoreboard.pending_events.size() != 0)
      scoreboard.report_mismatch("results still expected at end of run");
    if (scoreboard.error_count == 0) begin
      $display("tb_object_record_loader_parser: clean");
    end else begin
      $display("tb_object_record_loader_parser: errors");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/orlp_pkg.sv
hdl/object_record_loader_parser.sv
tb/sv/tb_object_record_loader_parser.sv
